// ===== hdl/abkf_pkg.sv =====
// ----------------------------------------------------------------------------
// abkf_pkg
// shared formats, saturation helpers and register indexes for the
// angle and gyro bias kalman filter
// ----------------------------------------------------------------------------
package abkf_pkg;

  localparam int ValueWidth   = 32;
  localparam int CovFracBits  = 28;
  localparam int DtFracBits   = 24;
  localparam int DtWidth      = 24;
  localparam int NoiseWidth   = 31;
  localparam int CfgIdxWidth  = 2;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_MEAS_NOISE  = 2'd2;

  localparam logic [NoiseWidth-1:0] ANGLE_NOISE_RST = 31'd536871;
  localparam logic [NoiseWidth-1:0] BIAS_NOISE_RST  = 31'd268435;
  localparam logic [NoiseWidth-1:0] MEAS_NOISE_RST  = 31'd2684355;
  localparam logic signed [ValueWidth-1:0] COV_ONE  = 32'sd268435456;

  localparam logic signed [63:0] VAL_MAX64 = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] VAL_MIN64 = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic                          ovf;
    logic signed [ValueWidth-1:0]  val;
  } sat_t;

  // clamp a wide signed value into the value range
  function automatic sat_t sat64(input logic signed [63:0] x);
    sat_t r;
    r.ovf = 1'b0;
    r.val = x[ValueWidth-1:0];
    if (x > VAL_MAX64) begin
      r.ovf = 1'b1;
      r.val = VAL_MAX64[ValueWidth-1:0];
    end else if (x < VAL_MIN64) begin
      r.ovf = 1'b1;
      r.val = VAL_MIN64[ValueWidth-1:0];
    end
    return r;
  endfunction

  // saturating add or subtract
  function automatic sat_t add_sat(input logic signed [ValueWidth-1:0] a,
                                   input logic signed [ValueWidth-1:0] b,
                                   input logic                         sub);
    logic signed [ValueWidth:0] s;
    sat_t r;
    s = sub ? ({a[ValueWidth-1], a} - {b[ValueWidth-1], b})
            : ({a[ValueWidth-1], a} + {b[ValueWidth-1], b});
    r.ovf = s[ValueWidth] ^ s[ValueWidth-1];
    r.val = s[ValueWidth-1:0];
    if (r.ovf) begin
      r.val = s[ValueWidth] ? VAL_MIN64[ValueWidth-1:0] : VAL_MAX64[ValueWidth-1:0];
    end
    return r;
  endfunction

  // magnitude of a signed value as unsigned
  function automatic logic [ValueWidth-1:0] mag32(input logic signed [ValueWidth-1:0] a);
    logic [ValueWidth-1:0] r;
    r = a[ValueWidth-1] ? ValueWidth'(-a) : ValueWidth'(a);
    return r;
  endfunction

endpackage

// ===== hdl/angle_bias_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// two-state kalman filter (angle, gyro bias) in fixed point, built around one
// shared 32x32 multiplier and one restoring divider under a small sequencer
// ----------------------------------------------------------------------------
// an update runs predict, covariance propagation, two gain divisions,
//   correction and covariance update in turn; both divisions are skipped
//   when the innovation variance is not positive
// a new input is taken only after the previous update has finished; the
//   gain divider computes one quotient bit per cycle
// input is taken only while the sequencer is idle; a waiting result does not
//   block the next input transfer, it only holds the next update at its end
// reset: angle 0, bias 0, covariance identity, noise registers at defaults
module angle_bias_kalman_filter import abkf_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]        cfg_index_i,
  input  logic [NoiseWidth-1:0]         cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [ValueWidth-1:0]  measured_angle_i,
  input  logic signed [ValueWidth-1:0]  measured_rate_i,
  input  logic [DtWidth-1:0]            time_step_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ValueWidth-1:0]  angle_estimate_o,
  output logic signed [ValueWidth-1:0]  corrected_rate_o,
  output logic                          overflow_flag_o
);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RATE  = 5'd1;
  localparam logic [4:0] S_M1    = 5'd2;
  localparam logic [4:0] S_A1    = 5'd3;
  localparam logic [4:0] S_T1    = 5'd4;
  localparam logic [4:0] S_T2    = 5'd5;
  localparam logic [4:0] S_T3    = 5'd6;
  localparam logic [4:0] S_T4    = 5'd7;
  localparam logic [4:0] S_T5    = 5'd8;
  localparam logic [4:0] S_CAA   = 5'd9;
  localparam logic [4:0] S_CBB   = 5'd10;
  localparam logic [4:0] S_SS    = 5'd11;
  localparam logic [4:0] S_DINIT = 5'd12;
  localparam logic [4:0] S_DITER = 5'd13;
  localparam logic [4:0] S_DRND  = 5'd14;
  localparam logic [4:0] S_Y     = 5'd15;
  localparam logic [4:0] S_MK0   = 5'd16;
  localparam logic [4:0] S_AK0   = 5'd17;
  localparam logic [4:0] S_BK1   = 5'd18;
  localparam logic [4:0] S_U1    = 5'd19;
  localparam logic [4:0] S_U2    = 5'd20;
  localparam logic [4:0] S_U3    = 5'd21;
  localparam logic [4:0] S_U4    = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  localparam logic [4:0] DIV_TOP = 5'd30;   // quotient bit 30 is the first one
  localparam logic [4:0] DIV_LOW = 5'd28;   // below this the dividend bits are zero

  logic [4:0] state_q, state_d;

  // noise registers
  logic [NoiseWidth-1:0] qa_q, qb_q, rm_q;

  // filter state
  logic signed [ValueWidth-1:0] ang_q, ang_d, bias_q, bias_d;
  logic signed [ValueWidth-1:0] caa_q, caa_d, cab_q, cab_d, cba_q, cba_d, cbb_q, cbb_d;

  // per-item working registers
  logic signed [ValueWidth-1:0] ma_q, ma_d, mr_q, mr_d;
  logic [DtWidth-1:0]           dt_q, dt_d;
  logic signed [ValueWidth-1:0] rate_q, rate_d, t_q, t_d, dp_q, dp_d;
  logic signed [ValueWidth-1:0] s_q, s_d, y_q, y_d, k0_q, k0_d, k1_q, k1_d;
  logic                         ovf_q, ovf_d;

  // shared multiplier: operands picked per state, product registered
  logic                         mul_en, mul_sh;
  logic signed [ValueWidth-1:0] mul_a, mul_b;
  logic [2*ValueWidth-1:0]      p_q;
  logic                         neg_q, sh_q;
  logic [2*ValueWidth-1:0]      rnd_u;
  logic signed [63:0]           mres;
  sat_t                         msat;

  // shared divider
  logic                          div_sel_q, div_sel_d, dneg_q, dneg_d, dsat_q, dsat_d;
  logic [NoiseWidth-1:0]         rem_q, rem_d, q_q, q_d;
  logic [2:0]                    nlow_q, nlow_d;
  logic [4:0]                    cnt_q, cnt_d;
  logic signed [ValueWidth-1:0]  dnum;
  logic [ValueWidth-1:0]         dn;
  logic                          dbig, dbit, rup;
  logic [ValueWidth:0]           dtrial;
  logic [NoiseWidth-1:0]         qfin;
  logic signed [ValueWidth-1:0]  kfin;
  logic                          kovf;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic signed [ValueWidth-1:0]  oang_q, oang_d, orate_q, orate_d;
  logic                          oovf_q, oovf_d;

  sat_t r1, r2, r3;

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign angle_estimate_o = oang_q;
  assign corrected_rate_o = orate_q;
  assign overflow_flag_o  = oovf_q;

  // product rounding: half away from zero on the magnitude
  always_comb begin
    if (sh_q) begin
      rnd_u = (p_q + (64'd1 << (CovFracBits - 1))) >> CovFracBits;
    end else begin
      rnd_u = (p_q + (64'd1 << (DtFracBits - 1))) >> DtFracBits;
    end
    mres = neg_q ? -$signed(rnd_u) : $signed(rnd_u);
    msat = sat64(mres);
  end

  // divider datapath
  always_comb begin
    dnum   = div_sel_q ? cba_q : caa_q;
    dn     = mag32(dnum);
    // quotient would exceed the cov range when n >= 8 * den
    dbig   = {2'b00, dn} >= {s_q[NoiseWidth-1:0], 3'b000};
    dbit   = (cnt_q >= DIV_LOW) ? nlow_q[cnt_q[1:0]] : 1'b0;
    dtrial = {1'b0, rem_q, dbit} - {2'b00, s_q[NoiseWidth-1:0]};
    rup    = {rem_q, 1'b0} >= {1'b0, s_q[NoiseWidth-1:0]};
    kovf   = dsat_q;
    qfin   = q_q;
    if (dsat_q) begin
      qfin = '1;
    end else if (rup) begin
      if (&q_q) begin
        kovf = 1'b1;
      end else begin
        qfin = q_q + 1'b1;
      end
    end
    kfin = dneg_q ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    ang_d       = ang_q;
    bias_d      = bias_q;
    caa_d       = caa_q;
    cab_d       = cab_q;
    cba_d       = cba_q;
    cbb_d       = cbb_q;
    ma_d        = ma_q;
    mr_d        = mr_q;
    dt_d        = dt_q;
    rate_d      = rate_q;
    t_d         = t_q;
    dp_d        = dp_q;
    s_d         = s_q;
    y_d         = y_q;
    k0_d        = k0_q;
    k1_d        = k1_q;
    ovf_d       = ovf_q;
    div_sel_d   = div_sel_q;
    dneg_d      = dneg_q;
    dsat_d      = dsat_q;
    rem_d       = rem_q;
    q_d         = q_q;
    nlow_d      = nlow_q;
    cnt_d       = cnt_q;
    mul_en      = 1'b0;
    mul_sh      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    r1          = '0;
    r2          = '0;
    r3          = '0;
    out_valid_d = out_valid_q;
    oang_d      = oang_q;
    orate_d     = orate_q;
    oovf_d      = oovf_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ma_d    = measured_angle_i;
          mr_d    = measured_rate_i;
          dt_d    = time_step_i;
          ovf_d   = 1'b0;
          state_d = S_RATE;
        end
      end
      // predict
      S_RATE: begin
        r1      = add_sat(mr_q, bias_q, 1'b1);
        rate_d  = r1.val;
        ovf_d   = ovf_q | r1.ovf;
        state_d = S_M1;
      end
      S_M1: begin
        mul_en  = 1'b1;
        mul_a   = $signed({8'd0, dt_q});
        mul_b   = rate_q;
        state_d = S_A1;
      end
      S_A1: begin
        r1      = add_sat(ang_q, msat.val, 1'b0);
        ang_d   = r1.val;
        ovf_d   = ovf_q | msat.ovf | r1.ovf;
        mul_en  = 1'b1;
        mul_a   = $signed({8'd0, dt_q});
        mul_b   = cbb_q;
        state_d = S_T1;
      end
      // covariance propagation; dt*cbb serves both t and dp
      S_T1: begin
        t_d     = msat.val;
        dp_d    = msat.val;
        ovf_d   = ovf_q | msat.ovf;
        state_d = S_T2;
      end
      S_T2: begin
        r1      = add_sat(t_q, cab_q, 1'b1);
        t_d     = r1.val;
        ovf_d   = ovf_q | r1.ovf;
        state_d = S_T3;
      end
      S_T3: begin
        r1      = add_sat(t_q, cba_q, 1'b1);
        t_d     = r1.val;
        ovf_d   = ovf_q | r1.ovf;
        state_d = S_T4;
      end
      S_T4: begin
        r1      = add_sat(t_q, $signed({1'b0, qa_q}), 1'b0);
        t_d     = r1.val;
        ovf_d   = ovf_q | r1.ovf;
        state_d = S_T5;
      end
      S_T5: begin
        mul_en  = 1'b1;
        mul_a   = $signed({8'd0, dt_q});
        mul_b   = t_q;
        state_d = S_CAA;
      end
      S_CAA: begin
        r1      = add_sat(caa_q, msat.val, 1'b0);
        r2      = add_sat(cab_q, dp_q, 1'b1);
        r3      = add_sat(cba_q, dp_q, 1'b1);
        caa_d   = r1.val;
        cab_d   = r2.val;
        cba_d   = r3.val;
        ovf_d   = ovf_q | msat.ovf | r1.ovf | r2.ovf | r3.ovf;
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, qb_q});
        mul_b   = $signed({8'd0, dt_q});
        state_d = S_CBB;
      end
      S_CBB: begin
        r1      = add_sat(cbb_q, msat.val, 1'b0);
        cbb_d   = r1.val;
        ovf_d   = ovf_q | msat.ovf | r1.ovf;
        state_d = S_SS;
      end
      // innovation variance, then the two gains
      S_SS: begin
        r1      = add_sat(caa_q, $signed({1'b0, rm_q}), 1'b0);
        s_d     = r1.val;
        ovf_d   = ovf_q | r1.ovf;
        if (r1.val[ValueWidth-1] || (r1.val == '0)) begin
          ovf_d   = 1'b1;
          k0_d    = '0;
          k1_d    = '0;
          state_d = S_Y;
        end else begin
          div_sel_d = 1'b0;
          state_d   = S_DINIT;
        end
      end
      S_DINIT: begin
        dneg_d = dnum[ValueWidth-1];
        dsat_d = dbig;
        rem_d  = NoiseWidth'(dn[ValueWidth-1:3]);
        nlow_d = dn[2:0];
        q_d    = '0;
        cnt_d  = DIV_TOP;
        state_d = dbig ? S_DRND : S_DITER;
      end
      S_DITER: begin
        if (!dtrial[ValueWidth]) begin
          rem_d = dtrial[NoiseWidth-1:0];
        end else begin
          rem_d = {rem_q[NoiseWidth-2:0], dbit};
        end
        q_d = {q_q[NoiseWidth-2:0], ~dtrial[ValueWidth]};
        if (cnt_q == '0) begin
          state_d = S_DRND;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DRND: begin
        ovf_d = ovf_q | kovf;
        if (!div_sel_q) begin
          k0_d      = kfin;
          div_sel_d = 1'b1;
          state_d   = S_DINIT;
        end else begin
          k1_d    = kfin;
          state_d = S_Y;
        end
      end
      // correction
      S_Y: begin
        r1      = add_sat(ma_q, ang_q, 1'b1);
        y_d     = r1.val;
        ovf_d   = ovf_q | r1.ovf;
        state_d = S_MK0;
      end
      S_MK0: begin
        mul_en  = 1'b1;
        mul_sh  = 1'b1;
        mul_a   = k0_q;
        mul_b   = y_q;
        state_d = S_AK0;
      end
      S_AK0: begin
        r1      = add_sat(ang_q, msat.val, 1'b0);
        ang_d   = r1.val;
        ovf_d   = ovf_q | msat.ovf | r1.ovf;
        mul_en  = 1'b1;
        mul_sh  = 1'b1;
        mul_a   = k1_q;
        mul_b   = y_q;
        state_d = S_BK1;
      end
      S_BK1: begin
        r1      = add_sat(bias_q, msat.val, 1'b0);
        bias_d  = r1.val;
        ovf_d   = ovf_q | msat.ovf | r1.ovf;
        mul_en  = 1'b1;
        mul_sh  = 1'b1;
        mul_a   = k0_q;
        mul_b   = caa_q;
        state_d = S_U1;
      end
      // covariance update, old caa and cab kept until their last product issues
      S_U1: begin
        t_d     = msat.val;
        ovf_d   = ovf_q | msat.ovf;
        mul_en  = 1'b1;
        mul_sh  = 1'b1;
        mul_a   = k1_q;
        mul_b   = caa_q;
        state_d = S_U2;
      end
      S_U2: begin
        r1      = add_sat(caa_q, t_q, 1'b1);
        r2      = add_sat(cba_q, msat.val, 1'b1);
        caa_d   = r1.val;
        cba_d   = r2.val;
        ovf_d   = ovf_q | msat.ovf | r1.ovf | r2.ovf;
        mul_en  = 1'b1;
        mul_sh  = 1'b1;
        mul_a   = k0_q;
        mul_b   = cab_q;
        state_d = S_U3;
      end
      S_U3: begin
        t_d     = msat.val;
        ovf_d   = ovf_q | msat.ovf;
        mul_en  = 1'b1;
        mul_sh  = 1'b1;
        mul_a   = k1_q;
        mul_b   = cab_q;
        state_d = S_U4;
      end
      S_U4: begin
        r1      = add_sat(cab_q, t_q, 1'b1);
        r2      = add_sat(cbb_q, msat.val, 1'b1);
        cab_d   = r1.val;
        cbb_d   = r2.val;
        ovf_d   = ovf_q | msat.ovf | r1.ovf | r2.ovf;
        state_d = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          oang_d      = ang_q;
          orate_d     = rate_q;
          oovf_d      = ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      qa_q        <= ANGLE_NOISE_RST;
      qb_q        <= BIAS_NOISE_RST;
      rm_q        <= MEAS_NOISE_RST;
      ang_q       <= '0;
      bias_q      <= '0;
      caa_q       <= COV_ONE;
      cab_q       <= '0;
      cba_q       <= '0;
      cbb_q       <= COV_ONE;
      cnt_q       <= '0;
      div_sel_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ang_q       <= ang_d;
      bias_q      <= bias_d;
      caa_q       <= caa_d;
      cab_q       <= cab_d;
      cba_q       <= cba_d;
      cbb_q       <= cbb_d;
      cnt_q       <= cnt_d;
      div_sel_q   <= div_sel_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ANGLE_NOISE: qa_q <= cfg_data_i;
          CFG_BIAS_NOISE:  qb_q <= cfg_data_i;
          CFG_MEAS_NOISE:  rm_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ma_q    <= ma_d;
    mr_q    <= mr_d;
    dt_q    <= dt_d;
    rate_q  <= rate_d;
    t_q     <= t_d;
    dp_q    <= dp_d;
    s_q     <= s_d;
    y_q     <= y_d;
    k0_q    <= k0_d;
    k1_q    <= k1_d;
    ovf_q   <= ovf_d;
    dneg_q  <= dneg_d;
    dsat_q  <= dsat_d;
    rem_q   <= rem_d;
    q_q     <= q_d;
    nlow_q  <= nlow_d;
    oang_q  <= oang_d;
    orate_q <= orate_d;
    oovf_q  <= oovf_d;
    if (mul_en) begin
      p_q   <= mag32(mul_a) * mag32(mul_b);
      neg_q <= mul_a[ValueWidth-1] ^ mul_b[ValueWidth-1];
      sh_q  <= mul_sh;
    end
  end

  // divider counter never leaves its range while iterating
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DITER) |-> (cnt_q <= DIV_TOP))
    else $error("divider count out of range");

  // partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DITER) |-> (rem_q < s_q[NoiseWidth-1:0]))
    else $error("divider remainder not below divisor");

  // a non-positive innovation variance skips both divisions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SS && state_d == S_Y) |=> (k0_q == '0 && k1_q == '0 && ovf_q))
    else $error("gains not cleared on bad innovation variance");

  // a finished update always ends in a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && state_d == S_IDLE) |=> out_valid_q)
    else $error("result lost at end of update");

endmodule
